// ===== hdl/rtm_pkg.sv =====
// rtm_pkg: shared constants, request and status codes, and allocator
// control and status structs for the radix tree map engine
// no dependencies
package rtm_pkg;

  localparam int BPL        = 4;
  localparam int KEY_BITS   = 32;
  localparam int POOL_NODES = 256;
  localparam int VALUE_BITS = 32;

  localparam int SLOTS    = 1 << BPL;
  localparam int NODE_W   = $clog2(POOL_NODES);
  localparam int SLOT_AW  = NODE_W + BPL;
  localparam int SLOT_W   = (VALUE_BITS > NODE_W) ? VALUE_BITS : NODE_W + 1;
  localparam int LEVELS   = (KEY_BITS + BPL - 1) / BPL;
  localparam int LV_W     = $clog2(LEVELS + 1);
  localparam int PATH_W   = $clog2(LEVELS);
  localparam int NEED_W   = LV_W + 1;
  localparam int OFF_W    = BPL + 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int FREE_W   = $clog2(POOL_NODES + 1);
  localparam int GROUPS   = 16;
  localparam int GRP_W    = $clog2(GROUPS);
  localparam int GSIZE    = POOL_NODES / GROUPS;
  localparam int GIDX_W   = $clog2(GSIZE);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_UPPER  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_OCCUPIED   = 3'd2,
    ST_POOL_FULL  = 3'd3,
    ST_ZERO_VALUE = 3'd4
  } status_t;

  typedef struct packed {
    logic              start;
    logic              release_node;
    logic [NODE_W-1:0] rel_id;
  } alloc_ctl_t;

  typedef struct packed {
    logic              done;
    logic [NODE_W-1:0] id;
    logic [FREE_W-1:0] free_cnt;
  } alloc_stat_t;

endpackage

// ===== hdl/rtm_alloc.sv =====
// rtm_alloc: node pool allocator, in-use bits, free count and a
// two-step lowest-free search (group, then node in group)
// depends on rtm_pkg
module rtm_alloc (
  input  logic               clk,
  input  logic               rst,
  input  rtm_pkg::alloc_ctl_t  ctl,
  output rtm_pkg::alloc_stat_t stat
);
  import rtm_pkg::*;

  logic [POOL_NODES-1:0] in_use;
  logic [FREE_W-1:0]     free_cnt;
  logic                  g_busy;
  logic                  i_busy;
  logic                  done;
  logic [GRP_W-1:0]      grp;
  logic [GRP_W-1:0]      grp_next;
  logic [GIDX_W-1:0]     gidx;
  logic [NODE_W-1:0]     id_r;

  always_comb begin
    grp_next = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (!(&in_use[g*GSIZE +: GSIZE])) grp_next = GRP_W'(g);
    end
  end

  always_comb begin
    gidx = '0;
    for (int i = GSIZE - 1; i >= 0; i--) begin
      if (!in_use[{grp, GIDX_W'(i)}]) gidx = GIDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use   <= '0;
      free_cnt <= FREE_W'(POOL_NODES);
      g_busy   <= 1'b0;
      i_busy   <= 1'b0;
      done     <= 1'b0;
    end else begin
      g_busy <= ctl.start;
      i_busy <= g_busy;
      done   <= i_busy;
      if (g_busy) grp <= grp_next;
      if (i_busy) begin
        in_use[{grp, gidx}] <= 1'b1;
        id_r <= {grp, gidx};
      end
      if (ctl.release_node) in_use[ctl.rel_id] <= 1'b0;
      if (i_busy && !ctl.release_node) free_cnt <= free_cnt - 1'b1;
      else if (ctl.release_node && !i_busy) free_cnt <= free_cnt + 1'b1;
    end
  end

  assign stat.done     = done;
  assign stat.id       = id_r;
  assign stat.free_cnt = free_cnt;

endmodule

// ===== hdl/radix_tree_map_engine_core.sv =====
// radix_tree_map_engine_core: radix tree map with insert, lookup, delete
// and upper bound over a node pool, run by one sequencer on one slot ram
// depends on rtm_pkg, rtm_alloc
//
//  channel | direction | beat fields               | handshake
//  request | in        | req_type, key, value      | in_valid / in_stall
//  result  | out       | status, result_value      | out_valid / out_stall
//
// one request at a time; each walk down the tree reads, then checks, a slot
// per level, and an insert of a new key within the current height walks
// the tree twice (check, then build); upper bound goes on to scan slots,
// delete climbs back node by node, and each node allocated needs a search
// plus a clear of its slots, all on the single slot ram read and write port
// synchronous reset empties the tree at once, no clearing pass
// in_stall is high from acceptance until the result is loaded into the
// output register; while a result stalls, the next one waits in S_DONE
module radix_tree_map_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] result_value
);
  import rtm_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE       = 19'h00001,
    S_START      = 19'h00002,
    S_CHECK      = 19'h00004,
    S_ALLOC_WAIT = 19'h00008,
    S_CLR        = 19'h00010,
    S_ROOT_SET   = 19'h00020,
    S_GROW_SET   = 19'h00040,
    S_DESC_RD    = 19'h00080,
    S_DESC_CK    = 19'h00100,
    S_LEAF       = 19'h00200,
    S_LINK       = 19'h00400,
    S_LINK_INC   = 19'h00800,
    S_LEAF_INC   = 19'h01000,
    S_DEL_CNT_RD = 19'h02000,
    S_DEL_CNT_WR = 19'h04000,
    S_DEL_UP     = 19'h08000,
    S_SCAN_RD    = 19'h10000,
    S_SCAN_CK    = 19'h20000,
    S_DONE       = 19'h40000
  } state_t;

  function automatic logic [BPL-1:0] digit_at(input logic [KEY_BITS-1:0] k,
                                              input logic [LV_W-1:0] l);
    logic [LV_W-1:0] lm1;
    lm1 = l - 1'b1;
    return BPL'(k >> (lm1 * BPL));
  endfunction

  function automatic logic [LV_W-1:0] key_height(input logic [KEY_BITS-1:0] k);
    logic [LV_W-1:0] h;
    h = LV_W'(1);
    for (int i = 1; i < LEVELS; i++) begin
      if (|BPL'(k >> (i * BPL))) h = LV_W'(i + 1);
    end
    return h;
  endfunction

  state_t state;
  state_t ret;
  req_t   op;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [LV_W-1:0]       hgt;
  logic [NODE_W-1:0]     root;
  logic [LV_W-1:0]       height;
  logic [NODE_W-1:0]     n;
  logic [LV_W-1:0]       lv;
  logic                  build;
  logic                  lm;
  logic [OFF_W-1:0]      o;
  logic [NEED_W-1:0]     need;
  logic [NODE_W-1:0]     aid;
  logic [BPL-1:0]        clr;
  logic [CNT_W-1:0]      curc;
  logic [VALUE_BITS-1:0] item;
  status_t               st_res;
  logic [VALUE_BITS-1:0] res;
  logic [NODE_W-1:0]     path [LEVELS];

  logic [SLOT_W-1:0] slot_mem [POOL_NODES*SLOTS];
  logic [SLOT_AW-1:0] s_raddr;
  logic [SLOT_AW-1:0] s_waddr;
  logic [SLOT_W-1:0]  s_wdata;
  logic               s_we;
  logic [SLOT_W-1:0]  s_rdata;

  logic [CNT_W-1:0] cnt_mem [POOL_NODES];
  logic [NODE_W-1:0] c_waddr;
  logic [CNT_W-1:0]  c_wdata;
  logic              c_we;
  logic [CNT_W-1:0]  c_rdata;
  logic [CNT_W-1:0]  c_dec;

  alloc_ctl_t  actl;
  alloc_stat_t astat;
  logic        grow;
  logic        pool_ok;

  rtm_alloc u_alloc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (actl),
    .stat (astat)
  );

  assign hgt      = key_height(key_r);
  assign grow     = (height == '0) || (hgt > height);
  assign pool_ok  = !(astat.free_cnt < FREE_W'(need));
  assign c_dec    = (c_rdata == '0) ? '0 : c_rdata - 1'b1;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (s_we) slot_mem[s_waddr] <= s_wdata;
    s_rdata <= slot_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) cnt_mem[c_waddr] <= c_wdata;
    c_rdata <= cnt_mem[n];
  end

  always_comb begin
    s_raddr = (state == S_SCAN_RD) ? {n, o[BPL-1:0]} : {n, digit_at(key_r, lv)};
    s_we    = 1'b0;
    s_waddr = {n, digit_at(key_r, lv)};
    s_wdata = '0;
    c_we    = 1'b0;
    c_waddr = n;
    c_wdata = '0;
    actl.start        = 1'b0;
    actl.release_node = 1'b0;
    actl.rel_id       = n;
    unique case (state)
      S_CHECK: begin
        actl.start = pool_ok && grow;
      end
      S_CLR: begin
        s_we    = 1'b1;
        s_waddr = {aid, clr};
        c_we    = (clr == '0);
        c_waddr = aid;
      end
      S_GROW_SET: begin
        s_we    = 1'b1;
        s_waddr = {aid, BPL'(0)};
        s_wdata = SLOT_W'(root) + 1'b1;
        c_we    = 1'b1;
        c_waddr = aid;
        c_wdata = CNT_W'(1);
        actl.start = (height + 1'b1) < hgt;
      end
      S_DESC_CK: begin
        actl.start = (op == REQ_INSERT) && build && (s_rdata == '0);
      end
      S_LINK: begin
        s_we    = 1'b1;
        s_wdata = SLOT_W'(aid) + 1'b1;
      end
      S_LINK_INC, S_LEAF_INC: begin
        c_we    = 1'b1;
        c_wdata = c_rdata + 1'b1;
      end
      S_LEAF: begin
        if (op == REQ_INSERT && build) begin
          s_we    = 1'b1;
          s_wdata = SLOT_W'(val_r);
        end else if (op == REQ_DELETE && s_rdata != '0) begin
          s_we = 1'b1;
        end
      end
      S_DEL_CNT_WR: begin
        c_we    = 1'b1;
        c_wdata = c_dec;
      end
      S_DEL_UP: begin
        if (curc == '0) begin
          actl.release_node = 1'b1;
          if (lv < height) begin
            s_we    = 1'b1;
            s_waddr = {path[PATH_W'(lv)], digit_at(key_r, lv + 1'b1)};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      root      <= '0;
      height    <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= req_t'(req_type);
            key_r <= key;
            val_r <= value;
            state <= S_START;
          end
        end
        S_START: begin
          build <= 1'b0;
          n     <= root;
          lv    <= height;
          if (op == REQ_INSERT) begin
            if (val_r == '0) begin
              st_res <= ST_ZERO_VALUE;
              res    <= '0;
              state  <= S_DONE;
            end else if (height == '0) begin
              need  <= NEED_W'(hgt);
              state <= S_CHECK;
            end else if (hgt > height) begin
              need  <= NEED_W'(hgt - height) + NEED_W'(hgt - 1'b1);
              state <= S_CHECK;
            end else begin
              state <= S_DESC_RD;
            end
          end else if (grow) begin
            st_res <= ST_NOT_FOUND;
            res    <= '0;
            state  <= S_DONE;
          end else begin
            state <= S_DESC_RD;
          end
        end
        S_CHECK: begin
          if (!pool_ok) begin
            st_res <= ST_POOL_FULL;
            res    <= '0;
            state  <= S_DONE;
          end else if (grow) begin
            ret   <= (height == '0) ? S_ROOT_SET : S_GROW_SET;
            state <= S_ALLOC_WAIT;
          end else begin
            build <= 1'b1;
            n     <= root;
            lv    <= height;
            state <= S_DESC_RD;
          end
        end
        S_ALLOC_WAIT: begin
          if (astat.done) begin
            aid   <= astat.id;
            clr   <= '0;
            state <= S_CLR;
          end
        end
        S_CLR: begin
          clr <= clr + 1'b1;
          if (&clr) state <= ret;
        end
        S_ROOT_SET: begin
          root   <= aid;
          height <= hgt;
          n      <= aid;
          lv     <= hgt;
          build  <= 1'b1;
          state  <= S_DESC_RD;
        end
        S_GROW_SET: begin
          root   <= aid;
          height <= height + 1'b1;
          if ((height + 1'b1) < hgt) begin
            ret   <= S_GROW_SET;
            state <= S_ALLOC_WAIT;
          end else begin
            build <= 1'b1;
            n     <= aid;
            lv    <= height + 1'b1;
            state <= S_DESC_RD;
          end
        end
        S_DESC_RD: begin
          path[PATH_W'(lv - 1'b1)] <= n;
          state <= (lv == LV_W'(1)) ? S_LEAF : S_DESC_CK;
        end
        S_DESC_CK: begin
          if (s_rdata != '0) begin
            n     <= NODE_W'(s_rdata - 1'b1);
            lv    <= lv - 1'b1;
            state <= S_DESC_RD;
          end else begin
            unique case (op)
              REQ_INSERT: begin
                if (build) begin
                  ret   <= S_LINK;
                  state <= S_ALLOC_WAIT;
                end else begin
                  need  <= NEED_W'(lv - 1'b1);
                  state <= S_CHECK;
                end
              end
              REQ_UPPER: begin
                o     <= {1'b0, digit_at(key_r, lv)} + OFF_W'(1);
                lm    <= 1'b0;
                state <= S_SCAN_RD;
              end
              default: begin
                st_res <= ST_NOT_FOUND;
                res    <= '0;
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_LINK: begin
          state <= S_LINK_INC;
        end
        S_LINK_INC: begin
          n     <= aid;
          lv    <= lv - 1'b1;
          state <= S_DESC_RD;
        end
        S_LEAF: begin
          unique case (op)
            REQ_INSERT: begin
              if (build) begin
                state <= S_LEAF_INC;
              end else if (s_rdata != '0) begin
                st_res <= ST_OCCUPIED;
                res    <= '0;
                state  <= S_DONE;
              end else begin
                need  <= '0;
                state <= S_CHECK;
              end
            end
            REQ_LOOKUP: begin
              st_res <= (s_rdata != '0) ? ST_OK : ST_NOT_FOUND;
              res    <= VALUE_BITS'(s_rdata);
              state  <= S_DONE;
            end
            REQ_DELETE: begin
              if (s_rdata == '0) begin
                st_res <= ST_NOT_FOUND;
                res    <= '0;
                state  <= S_DONE;
              end else begin
                item  <= VALUE_BITS'(s_rdata);
                state <= S_DEL_CNT_RD;
              end
            end
            default: begin
              o     <= {1'b0, digit_at(key_r, lv)};
              lm    <= 1'b0;
              state <= S_SCAN_RD;
            end
          endcase
        end
        S_LEAF_INC: begin
          st_res <= ST_OK;
          res    <= '0;
          state  <= S_DONE;
        end
        S_DEL_CNT_RD: begin
          state <= S_DEL_CNT_WR;
        end
        S_DEL_CNT_WR: begin
          curc  <= c_dec;
          state <= S_DEL_UP;
        end
        S_DEL_UP: begin
          if (curc == '0 && lv < height) begin
            n     <= path[PATH_W'(lv)];
            lv    <= lv + 1'b1;
            state <= S_DEL_CNT_RD;
          end else begin
            if (curc == '0) begin
              root   <= '0;
              height <= '0;
            end
            st_res <= ST_OK;
            res    <= item;
            state  <= S_DONE;
          end
        end
        S_SCAN_RD: begin
          if (o[BPL]) begin
            if (!lm && lv < height) begin
              n  <= path[PATH_W'(lv)];
              o  <= {1'b0, digit_at(key_r, lv + 1'b1)} + OFF_W'(1);
              lv <= lv + 1'b1;
            end else begin
              st_res <= ST_NOT_FOUND;
              res    <= '0;
              state  <= S_DONE;
            end
          end else begin
            state <= S_SCAN_CK;
          end
        end
        S_SCAN_CK: begin
          if (s_rdata != '0) begin
            if (lv == LV_W'(1)) begin
              st_res <= ST_OK;
              res    <= VALUE_BITS'(s_rdata);
              state  <= S_DONE;
            end else begin
              n     <= NODE_W'(s_rdata - 1'b1);
              lv    <= lv - 1'b1;
              o     <= '0;
              lm    <= 1'b1;
              state <= S_SCAN_RD;
            end
          end else begin
            o     <= o + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= st_res;
            result_value <= res;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
